// ===== rtl/avi_pkg.sv =====
// Shared types, constants and the VIC table for the AVI infoframe packet builder.
// No dependencies; imported by every module of the block.
package avi_pkg;

  localparam int unsigned VicW = 5;
  localparam int unsigned QueueDepth = 2;

  // shifted packet header: {0x0d, 0x02, 0x82} << 4, one nibble per row
  localparam logic [27:0] HdrShifted = 28'h0d02820;
  localparam logic [7:0]  HdrSum     = 8'h82 + 8'h02 + 8'h0d;

  localparam logic [8:0] Base43     = 9'd256;
  localparam logic [8:0] Base169    = 9'd384;
  localparam logic [8:0] PktStride  = 9'd32;

  localparam logic [7:0] Pb1Fixed    = 8'h01;
  localparam logic [7:0] Aspect43    = 8'h10;
  localparam logic [7:0] Aspect169   = 8'h20;
  localparam logic [7:0] Pb3Full     = 8'h88;
  localparam logic [7:0] Pb3Limited  = 8'h84;
  localparam logic [7:0] Pb5Fixed    = 8'h30;

  localparam logic [2:0] RowLast = 3'd6;
  localparam logic [1:0] PktLast = 2'd3;

  typedef enum logic [0:0] {
    REG_SPOOF_INTERLACE = 1'b0,
    REG_WIDESCREEN_VIC  = 1'b1
  } avi_reg_e;

  typedef enum logic [2:0] {
    MODE_240P  = 3'd0,
    MODE_288P  = 3'd1,
    MODE_480I  = 3'd2,
    MODE_576I  = 3'd3,
    MODE_480P  = 3'd4,
    MODE_576P  = 3'd5,
    MODE_OTHER = 3'd6
  } avi_mode_e;

  typedef struct packed {
    logic [2:0] video_mode;
    logic       line_rate_31khz;
  } avi_request_t;

  typedef struct packed {
    logic [8:0]  word_address;
    logic [11:0] word_group;
    logic        last_row;
  } avi_result_t;

  typedef struct packed {
    logic [VicW-1:0] vic;
    logic            rep;
  } avi_job_t;

  function automatic logic [VicW-1:0] vic_base(input logic [2:0] mode);
    logic [VicW-1:0] v;
    case (mode)
      MODE_240P: v = VicW'(8);
      MODE_288P: v = VicW'(23);
      MODE_480I: v = VicW'(6);
      MODE_576I: v = VicW'(21);
      MODE_480P: v = VicW'(2);
      MODE_576P: v = VicW'(17);
      default:   v = VicW'(2);  // other and unused codes report 480p
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/avi_front.sv =====
// Front end: configuration registers, request acceptance and VIC classification.
// Depends on avi_pkg; feeds the job queue.
module avi_front import avi_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [0:0]   cfg_data_i,
  input  logic         start_i,
  input  avi_request_t req_i,
  input  logic         full_i,
  output logic         busy_o,
  output logic         push_o,
  output avi_job_t     job_o
);

  logic spoof_q, spoof_d;
  logic wide_q, wide_d;
  logic [2:0] mode;

  always_comb begin
    spoof_d = spoof_q;
    wide_d  = wide_q;
    if (cfg_we_i) begin
      unique case (avi_reg_e'(cfg_idx_i))
        REG_SPOOF_INTERLACE: spoof_d = cfg_data_i[0];
        REG_WIDESCREEN_VIC:  wide_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spoof_q <= 1'b0;
      wide_q  <= 1'b0;
    end else begin
      spoof_q <= spoof_d;
      wide_q  <= wide_d;
    end
  end

  always_comb begin
    mode = req_i.video_mode;
    // with spoof_interlace set, 240p/288p reported as their interlaced counterparts
    if (spoof_q && (mode == MODE_240P || mode == MODE_288P)) begin
      mode = mode + 3'd2;
    end
    job_o.vic = vic_base(mode) + VicW'(wide_q);
    job_o.rep = ~req_i.line_rate_31khz;
  end

  assign busy_o = full_i;
  assign push_o = start_i && !full_i;

endmodule

// ===== rtl/avi_fifo.sv =====
// Short job queue between the front end and the row emitter.
// Depends on avi_pkg for the job type.
module avi_fifo import avi_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  avi_job_t data_i,
  input  logic     pop_i,
  output logic     valid_o,
  output logic     full_o,
  output avi_job_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  avi_job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? bump(wr_q) : wr_q;
    rd_d  = pop_i ? bump(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job queue underflow");
`endif

endmodule

// ===== rtl/avi_back.sv =====
// Back end: walks four packets of seven rows each and registers one row per cycle.
// Depends on avi_pkg; pulls jobs from the queue.
module avi_back import avi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  avi_job_t    job_i,
  output logic        pop_o,
  output logic        result_valid_o,
  output avi_result_t result_o
);

  avi_job_t    job_q;
  logic        active_q;
  logic [1:0]  pkt_q;
  logic [2:0]  row_q;
  logic        last_step;

  logic [7:0]  vic, aspect, pb3, pb5, sum, chk, body;
  logic [3:0]  hdr_nib;
  logic [8:0]  addr;
  avi_result_t row_res;
  logic        valid_q;
  avi_result_t res_q;

  assign last_step = active_q && (pkt_q == PktLast) && (row_q == RowLast);
  assign pop_o     = job_valid_i && (!active_q || last_step);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pkt_q    <= '0;
      row_q    <= '0;
    end else if (pop_o) begin
      active_q <= 1'b1;
      pkt_q    <= '0;
      row_q    <= '0;
    end else if (active_q) begin
      if (last_step) begin
        active_q <= 1'b0;
      end else if (row_q == RowLast) begin
        row_q <= '0;
        pkt_q <= pkt_q + 2'd1;
      end else begin
        row_q <= row_q + 3'd1;
      end
    end
  end

  // pkt_q[1]: 16:9 set, pkt_q[0]: limited range
  always_comb begin
    vic    = 8'(job_q.vic) + 8'(pkt_q[1]);
    aspect = pkt_q[1] ? Aspect169 : Aspect43;
    pb3    = pkt_q[0] ? Pb3Limited : Pb3Full;
    pb5    = Pb5Fixed | 8'(job_q.rep);
    sum    = HdrSum + Pb1Fixed + aspect + pb3 + vic + pb5;
    chk    = 8'd0 - sum;
    case (row_q)
      3'd0:    body = chk;
      3'd1:    body = Pb1Fixed;
      3'd2:    body = aspect;
      3'd3:    body = pb3;
      3'd4:    body = vic;
      3'd5:    body = pb5;
      default: body = 8'h00;
    endcase
    hdr_nib = HdrShifted[{row_q, 2'b00} +: 4];
    addr    = (pkt_q[1] ? Base169 : Base43) + (pkt_q[0] ? PktStride : 9'd0)
              + {4'd0, row_q, 2'b00};
    row_res.word_address = addr;
    for (int k = 0; k < 4; k++) begin
      row_res.word_group[3*k +: 3] = {body[2*k+1], body[2*k], hdr_nib[k]};
    end
    row_res.last_row = (pkt_q == PktLast) && (row_q == RowLast);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= row_res;
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> row_q <= RowLast)
    else $error("row counter out of range");
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_row |=> result_valid_o)
    else $error("gap inside a request's beats");
  a_last_flags_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_row |-> result_o.word_address == Base169 + PktStride
                                             + 9'(4 * RowLast))
    else $error("last beat at wrong address");
`endif

endmodule

// ===== rtl/avi_infoframe_packet_builder_core.sv =====
// AVI infoframe packet builder, top level.
// Depends on avi_pkg, avi_front, avi_fifo and avi_back.
//
// Usage:
//   Request channel: a request (video mode, 31 kHz flag) is taken on a rising
//   edge with start_i high and busy_o low. busy_o rises only when the job
//   queue (QueueDepth entries) is full.
//   Result channel: each request yields 28 beats, one per cycle with no gaps,
//   marked by result_valid_o: four packets (4:3 full, 4:3 limited, 16:9 full,
//   16:9 limited) of seven rows. last_row is set on the 28th beat.
//   When the emitter is free, a request passes the job queue and the emitter's
//   row counter, then the result register, before its first beat shows. The
//   row emitter produces one row per cycle; queued requests follow with no gap.
//   Config: cfg_we_i writes register cfg_idx_i (0 spoof_interlace,
//   1 widescreen_vic); the value is sampled when a request is accepted.
//   Reset clears both registers, the queue and the emitter; no beats follow.
//   The receiver cannot stall: each beat is valid for exactly one cycle.
module avi_infoframe_packet_builder_core import avi_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [0:0]   cfg_data_i,
  input  logic         start_i,
  input  avi_request_t req_i,
  output logic         busy_o,
  output logic         result_valid_o,
  output avi_result_t  result_o
);

  logic     push, pop, q_valid, q_full;
  avi_job_t push_job, head_job;

  avi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_i    (start_i),
    .req_i      (req_i),
    .full_i     (q_full),
    .busy_o     (busy_o),
    .push_o     (push),
    .job_o      (push_job)
  );

  avi_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .data_o  (head_job)
  );

  avi_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (head_job),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== tb/tb_avi_infoframe_packet_builder_core.sv =====
// Self-checking testbench for the AVI infoframe packet builder core.
// Depends on avi_pkg and the RTL top level; rows are predicted in-bench and
// compared beat by beat against the result strobe.
`timescale 1ns / 100ps

module tb_avi_infoframe_packet_builder_core;
  import avi_pkg::*;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned ReportMax     = 10;

  // header bits {0x0d, 0x02, 0x82} shifted up one nibble, four per row
  localparam logic [27:0] HeaderBits = 28'h0d02820;
  localparam logic [7:0]  HeaderSum  = 8'h91;
  localparam logic [7:0]  VicByMode [8] = '{8'd8, 8'd23, 8'd6, 8'd21, 8'd2, 8'd17, 8'd2, 8'd2};

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [0:0]   cfg_idx_i;
  logic [0:0]   cfg_data_i;
  logic         start_i;
  avi_request_t req_i;
  logic         busy_o;
  logic         result_valid_o;
  avi_result_t  result_o;

  avi_result_t pending_rows[$];
  logic        opt_spoof;
  logic        opt_wide;
  int unsigned requests_sent;
  int unsigned rows_checked;
  int unsigned mismatches;
  int unsigned option_sets;
  int unsigned idle_cycles;

  avi_infoframe_packet_builder_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start_i        (start_i),
    .req_i          (req_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Options are latched with the request, so the shadow copy is read here.
  function automatic void build_infoframe_rows(input avi_request_t r);
    logic [2:0]  mode;
    logic [7:0]  vic;
    logic [7:0]  body [7];
    logic [7:0]  sum;
    logic [2:0]  word;
    avi_result_t row_beat;
    mode = r.video_mode;
    if (opt_spoof && mode == MODE_240P) mode = MODE_480I;
    if (opt_spoof && mode == MODE_288P) mode = MODE_576I;
    vic = VicByMode[mode] + (opt_wide ? 8'd1 : 8'd0);
    for (int pkt = 0; pkt < 4; pkt++) begin
      body[1] = 8'h01;
      body[2] = (pkt < 2) ? 8'h10 : 8'h20;
      body[3] = pkt[0] ? 8'h84 : 8'h88;
      body[4] = (pkt < 2) ? vic : vic + 8'd1;
      body[5] = r.line_rate_31khz ? 8'h30 : 8'h31;
      body[6] = 8'h00;
      sum = HeaderSum;
      for (int i = 1; i < 7; i++) sum += body[i];
      body[0] = 8'd0 - sum;
      for (int row = 0; row < 7; row++) begin
        row_beat.word_address = 9'd256 + 9'(128 * (pkt / 2)) + 9'(32 * (pkt % 2))
                              + 9'(4 * row);
        row_beat.word_group = '0;
        for (int k = 0; k < 4; k++) begin
          word = {body[row][2*k+1], body[row][2*k], HeaderBits[4*row+k]};
          row_beat.word_group[3*k +: 3] = word;
        end
        row_beat.last_row = (pkt == 3 && row == 6);
        pending_rows.push_back(row_beat);
      end
    end
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so a burst continues without a gap.
  task automatic send_request(input avi_request_t r);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    build_infoframe_rows(r);
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start_i <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_rows.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_options(input logic spoof, input logic wide);
    pause_sender(1);
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SPOOF_INTERLACE;
    cfg_data_i <= spoof;
    @(negedge clk_i);
    cfg_idx_i  <= REG_WIDESCREEN_VIC;
    cfg_data_i <= wide;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    opt_spoof = spoof;
    opt_wide  = wide;
    option_sets++;
  endtask

  function automatic avi_request_t random_request();
    avi_request_t r;
    r.video_mode      = 3'($urandom_range(0, 7));
    r.line_rate_31khz = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // bursts of random length; some bursts run straight into the next one
  task automatic run_traffic(input int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_request(random_request());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
    end
  endtask

  task automatic test_mode_sweep();
    avi_request_t r;
    for (int m = 0; m < 8; m++) begin
      for (int rate = 0; rate < 2; rate++) begin
        r.video_mode      = 3'(m);
        r.line_rate_31khz = 1'(rate);
        send_request(r);
      end
    end
  endtask

  task automatic test_interlace_spoof();
    set_options(1'b1, 1'b0);
    run_traffic(120);
  endtask

  task automatic test_widescreen_vic();
    set_options(1'b0, 1'b1);
    run_traffic(120);
  endtask

  task automatic test_both_options();
    set_options(1'b1, 1'b1);
    run_traffic(120);
  endtask

  task automatic test_option_changes();
    repeat (5) begin
      set_options(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      run_traffic(26);
    end
    set_options(1'b0, 1'b0);
    run_traffic(10);
  endtask

  always @(posedge clk_i) begin
    avi_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected beat: addr %0d group %h last %b",
                   result_o.word_address, result_o.word_group, result_o.last_row);
      end else begin
        want = pending_rows.pop_front();
        rows_checked++;
        if (result_o.word_address !== want.word_address ||
            result_o.word_group !== want.word_group ||
            result_o.last_row !== want.last_row) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display({"beat %0d mismatch: addr exp %0d got %0d, ",
                      "group exp %h got %h, last exp %b got %b"},
                     rows_checked, want.word_address, result_o.word_address,
                     want.word_group, result_o.word_group,
                     want.last_row, result_o.last_row);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("timeout: no activity for %0d cycles", WatchdogLimit);
      $display("[avi_infoframe_packet_builder_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_SPOOF_INTERLACE;
    cfg_data_i    = 1'b0;
    start_i       = 1'b0;
    req_i         = '0;
    opt_spoof     = 1'b0;
    opt_wide      = 1'b0;
    requests_sent = 0;
    rows_checked  = 0;
    mismatches    = 0;
    option_sets   = 0;
    idle_cycles   = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_mode_sweep();
    test_interlace_spoof();
    test_widescreen_vic();
    test_both_options();
    test_option_changes();

    pause_sender(1);
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (pending_rows.size() != 0) begin
      mismatches++;
      $display("%0d expected beats never arrived", pending_rows.size());
    end

    $display("covered %0d requests, %0d rows checked, %0d option settings",
             requests_sent, rows_checked, option_sets);
    $display("all modes and line rates under every spoof/widescreen mix; %0d failures",
             mismatches);
    if (mismatches == 0) begin
      $display("[avi_infoframe_packet_builder_core] OK");
    end else begin
      $display("[avi_infoframe_packet_builder_core] ERROR");
    end
    $finish;
  end

endmodule
